### hdl/tsp_pkg.sv
// shared types and constants for the twinkle star pixel engine
package tsp_pkg;

  // sizes of the sparkle table and of the screen
  localparam int STAR_COUNT    = 128;
  localparam int STAR_ADDR_W   = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  // wide enough for screen limits and for coordinates plus one
  localparam int COORD_W       = 13;

  // field widths
  localparam int X_W       = 9;
  localparam int Y_W       = 8;
  localparam int LEVEL_W   = 6;
  localparam int INDEX_W   = 7;
  localparam int COLOUR_W  = 16;

  // divider operand widths: channel times phase over peak
  localparam int DIVIDEND_W = 2 * LEVEL_W;
  localparam int DIV_STEPS  = LEVEL_W;
  localparam int DIV_CNT_W  = 3;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // one sparkle table entry
  typedef struct packed {
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] phase;
    logic               rising;
  } star_entry_t;

  localparam int ENTRY_W = $bits(star_entry_t);

  // request into the shared divider
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [LEVEL_W-1:0]    divisor;
  } div_req_t;

  // answer from the shared divider
  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hdl/tsp_ram.sv
// generic single write port ram with registered read
module tsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/tsp_divider.sv
// restoring divider, one quotient bit per cycle, quotient known to fit level width
module tsp_divider (
  input  logic            clk,
  input  logic            rst,
  input  tsp_pkg::div_req_t req,
  output tsp_pkg::div_rsp_t rsp
);
  import tsp_pkg::*;

  logic [LEVEL_W-1:0]   rem;
  logic [LEVEL_W-1:0]   quo;
  logic [LEVEL_W-1:0]   divisor;
  logic [DIV_CNT_W-1:0] count;
  logic                 done;

  logic [LEVEL_W:0]     trial;
  logic [LEVEL_W:0]     diff;
  logic                 fits;

  // one shift, compare and subtract step
  always_comb begin
    trial = {rem, quo[LEVEL_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  // iteration state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem     <= req.dividend[DIVIDEND_W-1:LEVEL_W];
        quo     <= req.dividend[LEVEL_W-1:0];
        divisor <= req.divisor;
        count   <= DIV_CNT_W'(DIV_STEPS);
      end else if (count != '0) begin
        if (fits) begin
          rem <= diff[LEVEL_W-1:0];
          quo <= {quo[LEVEL_W-2:0], 1'b1};
        end else begin
          rem <= trial[LEVEL_W-1:0];
          quo <= {quo[LEVEL_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### hdl/twinkle_star_pixel_engine.sv
// top level: sparkle table, step sequencer and pixel emitter
//
// Requests enter on start; one is taken at a clock edge where start is high
// and busy is low. A load request (operation 0) writes the addressed sparkle
// entry at that edge and busy stays low, so the next request can follow in
// the next cycle. A step request (operation 1) raises busy and runs:
//   phase     read the entry, move the phase, write it back
//   channels  red, green, blue: one multiply, six divider steps, one capture
//   emit      one arm of the plus at a time: centre, left, right, up, down
// and busy stays high until the last arm; the shared bit-serial divider sets
// the length of a step.
// Each on-screen pixel shows for one cycle with pixel_valid high; the last
// one of a step carries last_pixel. The receiver cannot stall the block.
// accent_colour must be written through cfg_write/cfg_data while idle; the
// block does not enforce this. Synchronous reset (rst) sets the accent colour
// white, the sequencer idle; table entries are undefined until loaded.
module twinkle_star_pixel_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [tsp_pkg::INDEX_W-1:0]  star_index,
  input  logic [tsp_pkg::X_W-1:0]      load_x,
  input  logic [tsp_pkg::Y_W-1:0]      load_y,
  input  logic [tsp_pkg::LEVEL_W-1:0]  load_peak,
  input  logic [tsp_pkg::LEVEL_W-1:0]  load_phase,
  input  logic                         load_rising,
  input  logic                         cfg_write,
  input  logic [tsp_pkg::COLOUR_W-1:0] cfg_data,
  output logic                         pixel_valid,
  output logic [tsp_pkg::X_W-1:0]      pixel_x,
  output logic [tsp_pkg::Y_W-1:0]      pixel_y,
  output logic [tsp_pkg::COLOUR_W-1:0] pixel_colour,
  output logic                         last_pixel
);
  import tsp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_LAUNCH,
    S_DIVIDE,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef enum logic [2:0] {
    ARM_CENTRE,
    ARM_LEFT,
    ARM_RIGHT,
    ARM_UP,
    ARM_DOWN
  } arm_t;

  state_t               state;
  chan_t                ch;
  arm_t                 arm;
  logic [COLOUR_W-1:0]  accent_colour;
  logic [STAR_ADDR_W-1:0] index_q;
  star_entry_t          cur;
  logic [4:0]           arm_ok;
  logic [4:0]           red_q;
  logic [LEVEL_W-1:0]   grn_q;
  logic [4:0]           blu_q;

  logic                 accept;
  logic                 idx_ok;
  logic                 ram_we;
  logic [STAR_ADDR_W-1:0] ram_waddr;
  star_entry_t          ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  star_entry_t          rd_entry;
  star_entry_t          upd_entry;
  logic [LEVEL_W:0]     moved;
  logic                 under;
  logic                 rise_mid;
  logic [4:0]           arm_ok_next;
  logic [COORD_W-1:0]   xe;
  logic [COORD_W-1:0]   ye;
  logic                 x_in, xm_in, xp_in, y_in, ym_in, yp_in;
  logic [LEVEL_W-1:0]   chan_sel;
  logic [LEVEL_W-1:0]   q_val;
  logic                 later_ok;
  logic [X_W-1:0]       arm_x;
  logic [Y_W-1:0]       arm_y;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // request handshake and index range
  assign accept = start && !busy;
  assign idx_ok = (32'(star_index) < STAR_COUNT);

  // accent colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      accent_colour <= 16'hFFFF;
    end else if (cfg_write) begin
      accent_colour <= cfg_data;
    end
  end

  // phase move with clamps at zero and at the peak
  always_comb begin
    rd_entry = star_entry_t'(ram_rdata);
    under    = 1'b0;
    rise_mid = rd_entry.rising;
    if (rd_entry.rising) begin
      moved = {1'b0, rd_entry.phase} + (LEVEL_W+1)'(2);
    end else if (rd_entry.phase < LEVEL_W'(2)) begin
      moved    = '0;
      under    = 1'b1;
      rise_mid = 1'b1;
    end else begin
      moved = {1'b0, rd_entry.phase} - (LEVEL_W+1)'(2);
    end
    upd_entry = rd_entry;
    if (moved > {1'b0, rd_entry.peak}) begin
      upd_entry.phase  = rd_entry.peak;
      upd_entry.rising = 1'b0;
    end else begin
      upd_entry.phase  = moved[LEVEL_W-1:0];
      upd_entry.rising = rise_mid | under;
    end
  end

  // which arms of the plus land on screen
  always_comb begin
    xe    = COORD_W'(rd_entry.x);
    ye    = COORD_W'(rd_entry.y);
    x_in  = xe < COORD_W'(SCREEN_WIDTH);
    xp_in = (xe + COORD_W'(1)) < COORD_W'(SCREEN_WIDTH);
    xm_in = (xe != '0) && ((xe - COORD_W'(1)) < COORD_W'(SCREEN_WIDTH));
    y_in  = ye < COORD_W'(SCREEN_HEIGHT);
    yp_in = (ye + COORD_W'(1)) < COORD_W'(SCREEN_HEIGHT);
    ym_in = (ye != '0) && ((ye - COORD_W'(1)) < COORD_W'(SCREEN_HEIGHT));
    arm_ok_next = {x_in && yp_in, x_in && ym_in, xp_in && y_in, xm_in && y_in, x_in && y_in};
  end

  // table write: load at request, phase write-back during the step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = STAR_ADDR_W'(star_index);
    ram_wdata = '{x: load_x, y: load_y, peak: load_peak, phase: load_phase,
                  rising: load_rising};
    if (state == S_PHASE) begin
      ram_we    = 1'b1;
      ram_waddr = index_q;
      ram_wdata = upd_entry;
    end else if (accept && operation == OP_LOAD && idx_ok) begin
      ram_we = 1'b1;
    end
  end

  tsp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STAR_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (STAR_ADDR_W'(star_index)),
    .rdata (ram_rdata)
  );

  // channel select and product into the divider
  always_comb begin
    case (ch)
      CH_RED:   chan_sel = LEVEL_W'(accent_colour[15:11]);
      CH_GREEN: chan_sel = accent_colour[10:5];
      CH_BLUE:  chan_sel = LEVEL_W'(accent_colour[4:0]);
      default:  chan_sel = '0;
    endcase
    div_req.start    = (state == S_LAUNCH);
    div_req.dividend = DIVIDEND_W'(chan_sel) * DIVIDEND_W'(cur.phase);
    div_req.divisor  = cur.peak;
  end

  tsp_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // zero peak scales every channel to zero
  assign q_val = (cur.peak == '0) ? '0 : div_rsp.quotient;

  // pixel position and whether a later arm still follows
  always_comb begin
    arm_x    = cur.x;
    arm_y    = cur.y;
    later_ok = 1'b0;
    case (arm)
      ARM_CENTRE: later_ok = |arm_ok[4:1];
      ARM_LEFT: begin
        arm_x    = cur.x - X_W'(1);
        later_ok = |arm_ok[4:2];
      end
      ARM_RIGHT: begin
        arm_x    = cur.x + X_W'(1);
        later_ok = |arm_ok[4:3];
      end
      ARM_UP: begin
        arm_y    = cur.y - Y_W'(1);
        later_ok = arm_ok[4];
      end
      ARM_DOWN:   arm_y = cur.y + Y_W'(1);
      default:    later_ok = 1'b0;
    endcase
  end

  // step sequencer and registered pixel outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      busy        <= 1'b0;
      pixel_valid <= 1'b0;
      last_pixel  <= 1'b0;
      ch          <= CH_RED;
      arm         <= ARM_CENTRE;
    end else begin
      pixel_valid <= 1'b0;
      last_pixel  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && operation == OP_STEP && idx_ok) begin
            index_q <= STAR_ADDR_W'(star_index);
            busy    <= 1'b1;
            state   <= S_PHASE;
          end
        end
        S_PHASE: begin
          cur    <= upd_entry;
          arm_ok <= arm_ok_next;
          ch     <= CH_RED;
          state  <= S_LAUNCH;
        end
        S_LAUNCH: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_rsp.done) begin
            case (ch)
              CH_RED: begin
                red_q <= q_val[4:0];
                ch    <= CH_GREEN;
                state <= S_LAUNCH;
              end
              CH_GREEN: begin
                grn_q <= q_val;
                ch    <= CH_BLUE;
                state <= S_LAUNCH;
              end
              default: begin
                blu_q <= q_val[4:0];
                arm   <= ARM_CENTRE;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_EMIT: begin
          pixel_valid  <= arm_ok[arm];
          last_pixel   <= arm_ok[arm] && !later_ok;
          pixel_x      <= arm_x;
          pixel_y      <= arm_y;
          pixel_colour <= {red_q, grn_q, blu_q};
          if (arm == ARM_DOWN) begin
            busy  <= 1'b0;
            state <= S_IDLE;
          end else begin
            arm <= arm_t'(arm + 3'd1);
          end
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a pixel only follows a cycle of step work
  assert property (@(posedge clk) disable iff (rst) pixel_valid |-> $past(busy))
    else $error("pixel strobe without a step in progress");

  // a load request never makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_LOAD) |=> !busy)
    else $error("load request raised busy");

  // a step request in range always starts the sequencer
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_STEP && idx_ok) |=> (busy && state == S_PHASE))
    else $error("step request did not start the sequencer");

  // the last marker only rides on a shown pixel
  assert property (@(posedge clk) disable iff (rst) last_pixel |-> pixel_valid)
    else $error("last pixel marker without pixel strobe");

endmodule
